FILE: rtl/core/lob_pkg.sv
package lob_pkg;

	localparam int ID_W    = 32;
	localparam int PRICE_W = 10;
	localparam int QTY_W   = 31;
	localparam int TOTAL_W = 39;

	localparam logic [1:0] MD_ADD    = 2'd0;
	localparam logic [1:0] MD_CANCEL = 2'd1;
	localparam logic [1:0] MD_MODIFY = 2'd2;
	localparam logic [1:0] MD_DEPTH  = 2'd3;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_BADQ = 3'd1;
	localparam logic [2:0] ST_DUP  = 3'd2;
	localparam logic [2:0] ST_NF   = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic [1:0] EM_NONE   = 2'd0;
	localparam logic [1:0] EM_STATUS = 2'd1;
	localparam logic [1:0] EM_FLUSH  = 2'd2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [ID_W-1:0]    order_id;
		logic                      buy_sell;
		logic [PRICE_W-1:0]        price_tick;
		logic signed [31:0]        quantity;
		logic [5:0]                depth_levels;
	} ord_t;

	typedef struct packed {
		logic [2:0]          status;
		logic                bid_valid;
		logic [PRICE_W-1:0]  best_bid;
		logic                ask_valid;
		logic [PRICE_W-1:0]  best_ask;
		logic                level_valid;
		logic [PRICE_W-1:0]  level_price;
		logic [TOTAL_W-1:0]  level_total;
		logic                last;
	} rep_t;

	typedef struct packed {
		logic       ready;
		logic       load;
		logic       ctr_clr;
		logic       ctr_inc;
		logic       scan_chk;
		logic       ent_wr;
		logic       valid_set;
		logic       valid_clr;
		logic       lvl_wr;
		logic       clr_wr;
		logic       best_chk;
		logic       dep_rd;
		logic       dep_chk;
		logic [1:0] emit;
	} ctl_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       qbad;
		logic       op_ok;
		logic       ent_last;
		logic       lvl_last;
		logic       clr_last;
		logic       n_zero;
		logic       occ;
		logic       pend_v;
		logic       k_hit;
		logic       out_busy;
	} sts_t;

endpackage

FILE: rtl/core/lob_ram.sv
module lob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/lob_dp.sv
module lob_dp import lob_pkg::*; #(
	parameter int MAX_ORDERS   = 256,
	parameter int PRICE_LEVELS = 1024,
	parameter int DEPTH_MAX    = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  ord_t ord,
	input  logic rep_stall,
	input  ctl_t ctl,
	output sts_t sts,
	output logic rep_valid,
	output rep_t rep
);

	localparam int OW = $clog2(MAX_ORDERS);
	localparam int LW = $clog2(PRICE_LEVELS);
	localparam int CW = (OW > LW + 1) ? OW : LW + 1;
	localparam int TW = QTY_W + $clog2(MAX_ORDERS + 1);
	localparam int EW = ID_W + 1 + PRICE_W + QTY_W;
	localparam logic [31:0] PMAX = 32'(PRICE_LEVELS - 1);
	localparam logic [6:0]  DMAX = 7'(DEPTH_MAX);

	ord_t                ord_q;
	logic [CW-1:0]       ctr_q;
	logic [MAX_ORDERS-1:0] valid_q;
	logic                found_q, free_ok_q;
	logic [OW-1:0]       hit_idx_q, free_idx_q;
	logic                hit_side_q;
	logic [PRICE_W-1:0]  hit_price_q;
	logic [QTY_W-1:0]    hit_qty_q;
	logic                bid_v_q, ask_v_q;
	logic [PRICE_W-1:0]  bid_q, ask_q;
	logic [6:0]          k_q;
	logic                pend_v_q;
	logic [PRICE_W-1:0]  pend_price_q;
	logic [TOTAL_W-1:0]  pend_tot_q;
	logic                rep_v_q;
	rep_t                rep_q;

	logic                qbad;
	logic [PRICE_W-1:0]  price_sat;
	logic [QTY_W-1:0]    q31;
	logic [6:0]          n_eff;
	logic [2:0]          status;
	logic [OW-1:0]       idx;
	logic                e_v;
	logic [EW-1:0]       ent_rdata, ent_wdata;
	logic [OW-1:0]       ent_waddr;
	logic [ID_W-1:0]     rd_id;
	logic                rd_side;
	logic [PRICE_W-1:0]  rd_price;
	logic                side_sel;
	logic [PRICE_W-1:0]  price_sel;
	logic [31:0]         psel32, p32;
	logic [LW:0]         rmw_addr, dep_addr, lv_raddr, lv_waddr;
	logic [LW-1:0]       dep_p;
	logic [TW-1:0]       lv_rdata, lv_wdata;
	logic [63:0]         t64;
	logic [TOTAL_W-1:0]  lv_sat;
	logic                occ, out_busy;

	assign qbad      = (ord_q.quantity == '0) || ord_q.quantity[31];
	assign price_sat = (32'(ord_q.price_tick) >= 32'(PRICE_LEVELS)) ? PMAX[PRICE_W-1:0]
	                                                                : ord_q.price_tick;
	assign q31       = ord_q.quantity[QTY_W-1:0];
	assign n_eff     = ({1'b0, ord_q.depth_levels} > DMAX) ? DMAX : {1'b0, ord_q.depth_levels};

	always_comb begin
		status = ST_OK;
		unique case (ord_q.mode)
			MD_ADD: begin
				if (qbad)            status = ST_BADQ;
				else if (found_q)    status = ST_DUP;
				else if (!free_ok_q) status = ST_FULL;
			end
			MD_CANCEL: begin
				if (!found_q) status = ST_NF;
			end
			MD_MODIFY: begin
				if (!found_q)  status = ST_NF;
				else if (qbad) status = ST_BADQ;
			end
			default: status = ST_OK;
		endcase
	end

	assign idx      = ctr_q[OW-1:0];
	assign e_v      = valid_q[idx];
	assign rd_id    = ent_rdata[EW-1 -: ID_W];
	assign rd_side  = ent_rdata[PRICE_W + QTY_W];
	assign rd_price = ent_rdata[QTY_W +: PRICE_W];

	assign side_sel  = (ord_q.mode == MD_ADD) ? ord_q.buy_sell : hit_side_q;
	assign price_sel = (ord_q.mode == MD_ADD) ? price_sat : hit_price_q;
	assign ent_waddr = (ord_q.mode == MD_ADD) ? free_idx_q : hit_idx_q;
	assign ent_wdata = {ord_q.order_id, side_sel, price_sel, q31};

	lob_ram #(.WIDTH(EW), .DEPTH(MAX_ORDERS)) u_ent (
		.clk   (clk),
		.we    (ctl.ent_wr),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (idx),
		.rdata (ent_rdata)
	);

	assign psel32   = 32'(price_sel);
	assign rmw_addr = {side_sel, psel32[LW-1:0]};
	assign dep_p    = ord_q.buy_sell ? ctr_q[LW-1:0] : LW'(PRICE_LEVELS - 1) - ctr_q[LW-1:0];
	assign dep_addr = {ord_q.buy_sell, dep_p};
	assign p32      = 32'(dep_p);
	assign lv_raddr = ctl.dep_rd ? dep_addr : rmw_addr;
	assign lv_waddr = ctl.clr_wr ? ctr_q[LW:0] : rmw_addr;

	always_comb begin
		lv_wdata = '0;
		if (!ctl.clr_wr) begin
			case (ord_q.mode)
				MD_ADD:    lv_wdata = lv_rdata + TW'(q31);
				MD_CANCEL: lv_wdata = lv_rdata - TW'(hit_qty_q);
				default:   lv_wdata = lv_rdata - TW'(hit_qty_q) + TW'(q31);
			endcase
		end
	end

	lob_ram #(.WIDTH(TW), .DEPTH(2 * PRICE_LEVELS)) u_lvl (
		.clk   (clk),
		.we    (ctl.lvl_wr | ctl.clr_wr),
		.waddr (lv_waddr),
		.wdata (lv_wdata),
		.raddr (lv_raddr),
		.rdata (lv_rdata)
	);

	assign t64      = 64'(lv_rdata);
	assign lv_sat   = (t64 > 64'(TOTAL_MAX)) ? TOTAL_MAX : t64[TOTAL_W-1:0];
	assign occ      = (lv_rdata != '0);
	assign out_busy = rep_v_q && rep_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q     <= '0;
			valid_q   <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			bid_v_q   <= 1'b0;
			ask_v_q   <= 1'b0;
			k_q       <= '0;
			pend_v_q  <= 1'b0;
			rep_v_q   <= 1'b0;
		end else begin
			if (ctl.load || ctl.ctr_clr) ctr_q <= '0;
			else if (ctl.ctr_inc)        ctr_q <= ctr_q + 1'b1;
			if (ctl.load) begin
				found_q   <= 1'b0;
				free_ok_q <= 1'b0;
				bid_v_q   <= 1'b0;
				ask_v_q   <= 1'b0;
				k_q       <= '0;
				pend_v_q  <= 1'b0;
			end
			if (ctl.scan_chk) begin
				if (e_v && rd_id == ord_q.order_id && !found_q) found_q <= 1'b1;
				if (!e_v && !free_ok_q) free_ok_q <= 1'b1;
			end
			if (ctl.valid_set) valid_q[free_idx_q] <= 1'b1;
			if (ctl.valid_clr) valid_q[hit_idx_q]  <= 1'b0;
			if (ctl.best_chk && e_v) begin
				if (!rd_side && (!bid_v_q || rd_price > bid_q)) bid_v_q <= 1'b1;
				if (rd_side && (!ask_v_q || rd_price < ask_q))  ask_v_q <= 1'b1;
			end
			if (ctl.dep_chk && occ) begin
				pend_v_q <= 1'b1;
				k_q      <= k_q + 1'b1;
			end
			if (ctl.emit != EM_NONE || (ctl.dep_chk && occ && pend_v_q)) rep_v_q <= 1'b1;
			else if (!rep_stall)                                       rep_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) ord_q <= ord;
		if (ctl.scan_chk) begin
			if (e_v && rd_id == ord_q.order_id && !found_q) begin
				hit_idx_q   <= idx;
				hit_side_q  <= rd_side;
				hit_price_q <= rd_price;
				hit_qty_q   <= ent_rdata[QTY_W-1:0];
			end
			if (!e_v && !free_ok_q) free_idx_q <= idx;
		end
		if (ctl.best_chk && e_v) begin
			if (!rd_side && (!bid_v_q || rd_price > bid_q)) bid_q <= rd_price;
			if (rd_side && (!ask_v_q || rd_price < ask_q))  ask_q <= rd_price;
		end
		if (ctl.dep_chk && occ) begin
			pend_price_q <= p32[PRICE_W-1:0];
			pend_tot_q   <= lv_sat;
		end
		if (ctl.emit != EM_NONE || (ctl.dep_chk && occ && pend_v_q)) begin
			rep_q.bid_valid <= bid_v_q;
			rep_q.best_bid  <= bid_v_q ? bid_q : '0;
			rep_q.ask_valid <= ask_v_q;
			rep_q.best_ask  <= ask_v_q ? ask_q : '0;
			if (ctl.emit == EM_STATUS || (ctl.emit == EM_FLUSH && !pend_v_q)) begin
				rep_q.status      <= (ctl.emit == EM_STATUS) ? status : ST_OK;
				rep_q.level_valid <= 1'b0;
				rep_q.level_price <= '0;
				rep_q.level_total <= '0;
				rep_q.last        <= 1'b1;
			end else begin
				rep_q.status      <= ST_OK;
				rep_q.level_valid <= 1'b1;
				rep_q.level_price <= pend_price_q;
				rep_q.level_total <= pend_tot_q;
				rep_q.last        <= (ctl.emit == EM_FLUSH);
			end
		end
	end

	assign sts.mode     = ord_q.mode;
	assign sts.qbad     = qbad;
	assign sts.op_ok    = (status == ST_OK);
	assign sts.ent_last = (ctr_q == CW'(MAX_ORDERS - 1));
	assign sts.lvl_last = (ctr_q == CW'(PRICE_LEVELS - 1));
	assign sts.clr_last = (ctr_q == CW'(2 * PRICE_LEVELS - 1));
	assign sts.n_zero   = (n_eff == '0);
	assign sts.occ      = occ;
	assign sts.pend_v   = pend_v_q;
	assign sts.k_hit    = occ && (k_q + 1'b1 == n_eff);
	assign sts.out_busy = out_busy;

	assign rep_valid = rep_v_q;
	assign rep       = rep_q;

endmodule

FILE: rtl/core/lob_ctrl.sv
module lob_ctrl import lob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic ord_valid,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SREQ  = 4'd2;
	localparam logic [3:0] S_SCHK  = 4'd3;
	localparam logic [3:0] S_UPD   = 4'd4;
	localparam logic [3:0] S_LWR   = 4'd5;
	localparam logic [3:0] S_BREQ  = 4'd6;
	localparam logic [3:0] S_BCHK  = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;
	localparam logic [3:0] S_DREQ  = 4'd9;
	localparam logic [3:0] S_DCHK  = 4'd10;
	localparam logic [3:0] S_FLUSH = 4'd11;

	logic [3:0] state_q, state_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					ctl.ctr_clr = 1'b1;
					state_d     = S_IDLE;
				end else begin
					ctl.ctr_inc = 1'b1;
				end
			end
			S_IDLE: begin
				ctl.ready = 1'b1;
				if (ord_valid) begin
					ctl.load = 1'b1;
					state_d  = S_SREQ;
				end
			end
			S_SREQ: begin
				if (sts.mode == MD_DEPTH || (sts.mode == MD_ADD && sts.qbad)) state_d = S_BREQ;
				else                                                          state_d = S_SCHK;
			end
			S_SCHK: begin
				ctl.scan_chk = 1'b1;
				if (sts.ent_last) begin
					ctl.ctr_clr = 1'b1;
					state_d     = S_UPD;
				end else begin
					ctl.ctr_inc = 1'b1;
					state_d     = S_SREQ;
				end
			end
			S_UPD: begin
				if (sts.op_ok) begin
					unique case (sts.mode)
						MD_ADD: begin
							ctl.ent_wr    = 1'b1;
							ctl.valid_set = 1'b1;
						end
						MD_CANCEL: ctl.valid_clr = 1'b1;
						default:   ctl.ent_wr    = 1'b1;
					endcase
					state_d = S_LWR;
				end else begin
					state_d = S_BREQ;
				end
			end
			S_LWR: begin
				ctl.lvl_wr = 1'b1;
				state_d    = S_BREQ;
			end
			S_BREQ: state_d = S_BCHK;
			S_BCHK: begin
				ctl.best_chk = 1'b1;
				if (sts.ent_last) begin
					ctl.ctr_clr = 1'b1;
					if (sts.mode != MD_DEPTH) state_d = S_EMIT;
					else if (sts.n_zero)      state_d = S_FLUSH;
					else                      state_d = S_DREQ;
				end else begin
					ctl.ctr_inc = 1'b1;
					state_d     = S_BREQ;
				end
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					ctl.emit = EM_STATUS;
					state_d  = S_IDLE;
				end
			end
			S_DREQ: begin
				ctl.dep_rd = 1'b1;
				state_d    = S_DCHK;
			end
			S_DCHK: begin
				// keep the level read on the scanned tick while waiting
				ctl.dep_rd = 1'b1;
				if (!(sts.occ && sts.pend_v && sts.out_busy)) begin
					ctl.dep_chk = 1'b1;
					if (sts.k_hit || sts.lvl_last) begin
						state_d = S_FLUSH;
					end else begin
						ctl.ctr_inc = 1'b1;
						state_d     = S_DREQ;
					end
				end
			end
			S_FLUSH: begin
				if (!sts.out_busy) begin
					ctl.emit = EM_FLUSH;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/limit_order_book_unit.sv
// channel | word  | handshake                  | direction
// ord     | ord_t | ord_valid / ord_stall      | command in
// rep     | rep_t | rep_valid / rep_stall      | result out
// Add, cancel, modify: a search sweep and a best-price sweep of the order RAM, with a level
// write between them unless rejected; an add with a bad quantity does only the second sweep.
// Depth query: the best-price sweep, then a scan of price levels.
// After reset the level RAM is cleared, with stall high.
// A finished word waits in the output register while the next command is taken;
// a held word holds back the next emit until rep_stall falls.
module limit_order_book_unit import lob_pkg::*; #(
	parameter int MAX_ORDERS   = 256,
	parameter int PRICE_LEVELS = 1024,
	parameter int DEPTH_MAX    = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic ord_valid,
	output logic ord_stall,
	input  ord_t ord,
	output logic rep_valid,
	input  logic rep_stall,
	output rep_t rep
);

	ctl_t ctl;
	sts_t sts;

	lob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ord_valid (ord_valid),
		.sts       (sts),
		.ctl       (ctl)
	);

	lob_dp #(
		.MAX_ORDERS   (MAX_ORDERS),
		.PRICE_LEVELS (PRICE_LEVELS),
		.DEPTH_MAX    (DEPTH_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ord       (ord),
		.rep_stall (rep_stall),
		.ctl       (ctl),
		.sts       (sts),
		.rep_valid (rep_valid),
		.rep       (rep)
	);

	assign ord_stall = !ctl.ready;

endmodule

FILE: rtl/core/lob_checker.sv
module lob_checker import lob_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rep_valid,
	input logic rep_stall,
	input rep_t rep
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && rep_stall |=> rep_valid)
		else $error("result word dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && rep_stall |=> $stable(rep))
		else $error("result word changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && rep.status != ST_OK |-> rep.last && !rep.level_valid)
		else $error("error status on a depth word");

	a_bid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && !rep.bid_valid |-> rep.best_bid == '0)
		else $error("best bid set without bid");

endmodule

bind limit_order_book_unit lob_checker u_chk (.*);
